/* design/oes_pkg.sv */
// ----------------------------------------------------------------------------
// oes_pkg
// Types, constants and helper functions of the octant edge shift pipeline.
// ----------------------------------------------------------------------------
package oes_pkg;

  localparam int MaxLevel = 19;
  localparam int LevW     = 5;
  localparam int CoordW   = 19;
  // working coordinates need sign and headroom while the walk drifts
  localparam int CW       = MaxLevel + 3;
  localparam int NumSteps = MaxLevel - 1;
  localparam logic [LevW-1:0] LevTop = LevW'(MaxLevel - 1);

  localparam logic [1:0] ModeUp  = 2'd0;
  localparam logic [1:0] ModeMid = 2'd1;
  localparam logic [1:0] ModeDn  = 2'd2;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
  } oct_t;

  typedef struct packed {
    oct_t [2:0]      w;
    logic [LevW-1:0] lev;
    logic [1:0]      axis;
    logic [3:0]      eidx;
    logic            done;
  } stage_t;

  typedef struct packed {
    oct_t mid;
    oct_t up;
    oct_t dn;
  } sibs_t;

  // contact pattern of each edge
  function automatic logic [5:0] contact_pat(input logic [3:0] e);
    logic [5:0] p;
    case (e)
      4'd0:    p = 6'h14;
      4'd1:    p = 6'h18;
      4'd2:    p = 6'h24;
      4'd3:    p = 6'h28;
      4'd4:    p = 6'h11;
      4'd5:    p = 6'h12;
      4'd6:    p = 6'h21;
      4'd7:    p = 6'h22;
      4'd8:    p = 6'h05;
      4'd9:    p = 6'h06;
      4'd10:   p = 6'h09;
      4'd11:   p = 6'h0a;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

  // octant length at a level
  function automatic logic [CW-1:0] side_len(input logic [LevW-1:0] lev);
    logic [LevW-1:0] sh;
    sh = LevW'(MaxLevel) - lev;
    return CW'(1) << sh;
  endfunction

  // side of the crossing axis a is the upper one
  function automatic logic cross_plus(input logic [1:0] axis, input logic [3:0] e,
                                      input int a);
    logic first;
    first = (a == 0) || (a == 1 && axis == 2'd0);
    return first ? e[0] : e[1];
  endfunction

  function automatic oct_t sib(input oct_t o, input logic [LevW-1:0] lev,
                               input logic [1:0] axis, input logic [3:0] e,
                               input logic [1:0] mode);
    oct_t s;
    logic [CW-1:0] h;
    logic want;
    h = side_len(lev);
    for (int a = 0; a < 3; a++) begin
      if (a == int'(axis)) begin
        case (mode)
          ModeUp:  want = 1'b0;
          ModeDn:  want = 1'b1;
          default: want = |(o.c[a] & h);
        endcase
      end else begin
        want = cross_plus(axis, e, a);
      end
      s.c[a] = (o.c[a] & ~h) | (want ? h : '0);
    end
    return s;
  endfunction

  // mid, up and down octants of one pass
  function automatic sibs_t make_sibs(input stage_t s);
    sibs_t r;
    r.up  = sib(s.w[0], s.lev, s.axis, s.eidx, ModeUp);
    r.mid = sib(s.w[1], s.lev, s.axis, s.eidx, ModeMid);
    r.dn  = sib(s.w[2], s.lev, s.axis, s.eidx, ModeDn);
    return r;
  endfunction

endpackage

/* design/oes_in_if.sv */
// ----------------------------------------------------------------------------
// oes_in_if
// Input channel: one octant and one cube edge per word.
// ----------------------------------------------------------------------------
interface oes_in_if;
  logic                valid;
  logic                ready;
  logic [18:0]         in_x;
  logic [18:0]         in_y;
  logic [18:0]         in_z;
  logic [4:0]          in_level;
  logic [3:0]          edge_index;

  modport source (output valid, in_x, in_y, in_z, in_level, edge_index, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_level, edge_index, output ready);
endinterface

/* design/oes_out_if.sv */
// ----------------------------------------------------------------------------
// oes_out_if
// Output channel: shifted octant and its two neighbours per word.
// ----------------------------------------------------------------------------
interface oes_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] mid_x;
  logic [18:0] mid_y;
  logic [18:0] mid_z;
  logic [18:0] up_x;
  logic [18:0] up_y;
  logic [18:0] up_z;
  logic [18:0] down_x;
  logic [18:0] down_y;
  logic [18:0] down_z;
  logic [4:0]  out_level;

  modport source (output valid, mid_x, mid_y, mid_z, up_x, up_y, up_z,
                  down_x, down_y, down_z, out_level, input ready);
  modport sink   (input valid, mid_x, mid_y, mid_z, up_x, up_y, up_z,
                  down_x, down_y, down_z, out_level, output ready);
endinterface

/* design/oes_prep.sv */
// ----------------------------------------------------------------------------
// oes_prep
// Entry stage: fold the edge index, saturate the level, align coordinates.
// ----------------------------------------------------------------------------
module oes_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [18:0]          x_i,
  input  logic [18:0]          y_i,
  input  logic [18:0]          z_i,
  input  logic [4:0]           level_i,
  input  logic [3:0]           edge_i,
  output logic                 valid_o,
  output oes_pkg::stage_t      stage_o
);
  import oes_pkg::*;

  stage_t          stage_d, stage_q;
  logic            valid_q;
  logic [3:0]      e;
  logic [LevW-1:0] lev;
  logic [CW-1:0]   keep;

  // build the first working triple
  always_comb begin
    e       = (edge_i > 4'd11) ? {2'b10, edge_i[1:0]} : edge_i;
    lev     = (level_i > LevTop) ? LevTop : level_i;
    keep    = ~(side_len(lev) - CW'(1));
    stage_d = '0;
    stage_d.w[0].c[0] = {{(CW-CoordW){1'b0}}, x_i} & keep;
    stage_d.w[0].c[1] = {{(CW-CoordW){1'b0}}, y_i} & keep;
    stage_d.w[0].c[2] = {{(CW-CoordW){1'b0}}, z_i} & keep;
    stage_d.w[1] = stage_d.w[0];
    stage_d.w[2] = stage_d.w[0];
    stage_d.lev  = lev;
    stage_d.axis = e[3:2];
    stage_d.eidx = e;
    stage_d.done = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;
endmodule

/* design/oes_step.sv */
// ----------------------------------------------------------------------------
// oes_step
// One level of the walk: stop on the contact pattern or at level zero, else
// climb one level and move the three octants toward the edge.
// ----------------------------------------------------------------------------
module oes_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  oes_pkg::stage_t      stage_i,
  output logic                 valid_o,
  output oes_pkg::stage_t      stage_o
);
  import oes_pkg::*;

  stage_t        stage_d, stage_q;
  logic          valid_q;
  oct_t          mid;
  logic [CW-1:0] h;
  logic [CW-1:0] h2;
  logic [CW-1:0] th;
  logic [5:0]    face;
  logic          stop;

  always_comb begin
    stage_d = stage_i;
    h       = side_len(stage_i.lev);
    h2      = h << 1;
    th      = CW'(1 << MaxLevel) - h;
    mid     = sib(stage_i.w[1], stage_i.lev, stage_i.axis, stage_i.eidx, ModeMid);
    // gather the faces that mid touches
    face    = '0;
    for (int a = 0; a < 3; a++) begin
      if (a != int'(stage_i.axis)) begin
        face[2*a]   = $signed(mid.c[a]) <= 0;
        face[2*a+1] = $signed(mid.c[a]) >= $signed(th);
      end
    end
    stop = (face == contact_pat(stage_i.eidx)) || (stage_i.lev == '0);
    // climb one level and advance toward the edge
    if (!stage_i.done) begin
      if (stop) begin
        stage_d.done = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          for (int a = 0; a < 3; a++) begin
            stage_d.w[i].c[a] = stage_i.w[i].c[a] & ~h;
            if (a != int'(stage_i.axis)) begin
              stage_d.w[i].c[a] = cross_plus(stage_i.axis, stage_i.eidx, a) ?
                                  stage_d.w[i].c[a] + h2 : stage_d.w[i].c[a] - h2;
            end else if (i == 0) begin
              stage_d.w[i].c[a] = stage_d.w[i].c[a] + h2;
            end else if (i == 2) begin
              stage_d.w[i].c[a] = stage_d.w[i].c[a] - h2;
            end
          end
        end
        stage_d.lev = stage_i.lev - LevW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;
endmodule

/* design/oes_final.sv */
// ----------------------------------------------------------------------------
// oes_final
// Output stage: form mid, up and down of the last pass and clamp into root.
// ----------------------------------------------------------------------------
module oes_final (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  oes_pkg::stage_t      stage_i,
  output logic                 valid_o,
  output oes_pkg::sibs_t       res_o,
  output logic [4:0]           lev_o
);
  import oes_pkg::*;

  sibs_t           res_d, res_q;
  logic [LevW-1:0] lev_q;
  logic            valid_q;
  logic [CW-1:0]   th;

  function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v,
                                          input logic [CW-1:0] top);
    logic [CW-1:0] r;
    if ($signed(v) < 0) begin
      r = '0;
    end else if ($signed(v) >= $signed(CW'(1 << MaxLevel))) begin
      r = top;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // clamp the three octants, mid only off the edge axis
  always_comb begin
    th    = CW'(1 << MaxLevel) - side_len(stage_i.lev);
    res_d = make_sibs(stage_i);
    for (int a = 0; a < 3; a++) begin
      if (a != int'(stage_i.axis)) begin
        res_d.mid.c[a] = clamp(res_d.mid.c[a], th);
      end
      res_d.up.c[a] = clamp(res_d.up.c[a], th);
      res_d.dn.c[a] = clamp(res_d.dn.c[a], th);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      lev_q <= stage_i.lev;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign lev_o   = lev_q;
endmodule

/* design/octant_edge_shift.sv */
// ----------------------------------------------------------------------------
// octant_edge_shift
// Pushes an octant toward a cube edge and returns it with its neighbours
// along the edge, one level of the walk per pipeline stage.
// ----------------------------------------------------------------------------
//   channel  dir  word
//   in_i     in   in_x, in_y, in_z, in_level, edge_index
//   out_o    out  mid_*, up_*, down_*, out_level
//
// The pipeline has one entry stage, 18 level stages and one output stage.
// Unstalled, a new word enters every cycle; throughput is one word per cycle.
// The whole pipeline advances together; it holds when out_o is full and
// not taken, and in_i.ready falls for exactly those cycles.
// Reset clears every stage valid bit.
module octant_edge_shift (
  input  logic       clk_i,
  input  logic       rst_ni,
  oes_in_if.sink     in_i,
  oes_out_if.source  out_o
);
  import oes_pkg::*;

  logic   adv;
  logic   v   [NumSteps+1];
  stage_t stg [NumSteps+1];
  sibs_t  res;
  logic [LevW-1:0] lev;
  logic   out_v;

  // advance all stages while the output slot is free or taken
  assign adv        = !out_v || out_o.ready;
  assign in_i.ready = adv;

  oes_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .x_i     (in_i.in_x),
    .y_i     (in_i.in_y),
    .z_i     (in_i.in_z),
    .level_i (in_i.in_level),
    .edge_i  (in_i.edge_index),
    .valid_o (v[0]),
    .stage_o (stg[0])
  );

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    oes_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v[k]),
      .stage_i (stg[k]),
      .valid_o (v[k+1]),
      .stage_o (stg[k+1])
    );
  end

  oes_final u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v[NumSteps]),
    .stage_i (stg[NumSteps]),
    .valid_o (out_v),
    .res_o   (res),
    .lev_o   (lev)
  );

  // drive the output word
  assign out_o.valid     = out_v;
  assign out_o.mid_x     = res.mid.c[0][CoordW-1:0];
  assign out_o.mid_y     = res.mid.c[1][CoordW-1:0];
  assign out_o.mid_z     = res.mid.c[2][CoordW-1:0];
  assign out_o.up_x      = res.up.c[0][CoordW-1:0];
  assign out_o.up_y      = res.up.c[1][CoordW-1:0];
  assign out_o.up_z      = res.up.c[2][CoordW-1:0];
  assign out_o.down_x    = res.dn.c[0][CoordW-1:0];
  assign out_o.down_y    = res.dn.c[1][CoordW-1:0];
  assign out_o.down_z    = res.dn.c[2][CoordW-1:0];
  assign out_o.out_level = lev;

  // the walk has ended by the last level stage
  a_walk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v[NumSteps] |-> (stg[NumSteps].done || stg[NumSteps].lev == '0))
    else $error("walk not finished at last stage");

  // a stalled output keeps the input side closed
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v && !out_o.ready) |-> !in_i.ready)
    else $error("input taken during output stall");

  // result level never exceeds the deepest input level
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v |-> (lev <= LevTop))
    else $error("result level out of range");
endmodule

/* verif/tb_octant_edge_shift.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives octant/edge words into octant_edge_shift at random rates, predicts
// the mid, up and down octants with a behavioral level walk, and compares
// every result word field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import oes_pkg::*;

  typedef struct packed {
    logic [18:0] x, y, z;
    logic [4:0]  lev;
    logic [3:0]  e;
  } req_t;

  typedef struct packed {
    logic [18:0] mx, my, mz, ux, uy, uz, dx, dy, dz;
    logic [4:0]  lev;
  } shift_t;

  localparam int WatchdogLimit = 2000;

  logic clk_i;
  logic rst_ni;
  oes_in_if  in_if ();
  oes_out_if out_if ();

  octant_edge_shift dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  shift_t expected_q[$];
  int     fail_cnt;
  int     idle_cnt;
  bit     quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Push the octant toward the edge one level at a time, then clamp.
  function automatic shift_t edge_shift(input req_t r);
    longint w[3][3], md[3], up[3], dn[3], h, th, root;
    int     e, axis, lev, cid, outface, sid[3], stp[3], pat[12];
    shift_t s;
    pat = '{'h14, 'h18, 'h24, 'h28, 'h11, 'h12, 'h21, 'h22, 'h05, 'h06, 'h09, 'h0a};
    root = 64'sd1 << MaxLevel;
    e = r.e;
    if (e > 11) e = 8 + (e & 3);
    axis = e >> 2;
    lev = (r.lev > MaxLevel - 1) ? MaxLevel - 1 : r.lev;
    h = 64'sd1 << (MaxLevel - lev);
    for (int a = 0; a < 3; a++) begin
      longint v;
      v = (a == 0) ? r.x : (a == 1) ? r.y : r.z;
      v = v & (root - 1) & ~(h - 1);
      for (int i = 0; i < 3; i++) w[i][a] = v;
    end
    forever begin
      h = 64'sd1 << (MaxLevel - lev);
      th = root - h;
      cid = 0;
      for (int a = 0; a < 3; a++) if ((w[1][a] & h) != 0) cid |= 1 << a;
      if (axis == 0) begin
        sid[0] = 2 * e; sid[1] = 2 * e + (cid & 1); sid[2] = 2 * e + 1;
        stp = '{0, 2 * (e & 1) - 1, (e & 2) - 1};
      end else if (axis == 1) begin
        sid[0] = 2 * (e & 2) + (e & 1);
        sid[1] = sid[0] + (cid & 2); sid[2] = sid[0] + 2;
        stp = '{2 * (e & 1) - 1, 0, (e & 2) - 1};
      end else begin
        sid[0] = e - 8; sid[1] = sid[0] + (cid & 4); sid[2] = sid[0] + 4;
        stp = '{2 * (e & 1) - 1, (e & 2) - 1, 0};
      end
      for (int a = 0; a < 3; a++) begin
        up[a] = w[0][a] - (((w[0][a] & h) != 0) ? h : 0) + (((sid[0] >> a) & 1) ? h : 0);
        md[a] = w[1][a] - (((w[1][a] & h) != 0) ? h : 0) + (((sid[1] >> a) & 1) ? h : 0);
        dn[a] = w[2][a] - (((w[2][a] & h) != 0) ? h : 0) + (((sid[2] >> a) & 1) ? h : 0);
      end
      outface = 0;
      for (int a = 0; a < 3; a++) if (stp[a] != 0) begin
        if (md[a] <= 0) outface |= 1 << (2 * a);
        if (md[a] >= th) outface |= 2 << (2 * a);
      end
      if (outface == pat[e] || lev == 0) break;
      // climb one level and step toward the edge
      for (int i = 0; i < 3; i++)
        for (int a = 0; a < 3; a++) begin
          w[i][a] -= ((w[i][a] & h) != 0) ? h : 0;
          w[i][a] += stp[a] * (h << 1);
        end
      w[0][axis] += h << 1;
      w[2][axis] -= h << 1;
      lev--;
    end
    for (int a = 0; a < 3; a++) begin
      if (stp[a] != 0) begin
        if (md[a] < 0) md[a] = 0;
        if (md[a] >= root) md[a] = th;
      end
      if (up[a] < 0) up[a] = 0;
      if (up[a] >= root) up[a] = th;
      if (dn[a] < 0) dn[a] = 0;
      if (dn[a] >= root) dn[a] = th;
    end
    s.mx = md[0][18:0]; s.my = md[1][18:0]; s.mz = md[2][18:0];
    s.ux = up[0][18:0]; s.uy = up[1][18:0]; s.uz = up[2][18:0];
    s.dx = dn[0][18:0]; s.dy = dn[1][18:0]; s.dz = dn[2][18:0];
    s.lev = lev[4:0];
    return s;
  endfunction

  // Send one word, with a random gap before it unless quiet.
  task automatic send_word(input req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.in_x       <= r.x;
    in_if.in_y       <= r.y;
    in_if.in_z       <= r.z;
    in_if.in_level   <= r.lev;
    in_if.edge_index <= r.e;
    do @(posedge clk_i); while (!in_if.ready);
    expected_q.push_back(edge_shift(r));
  endtask

  // Make a random octant aligned to a random level.
  function automatic req_t rand_octant(input logic [3:0] e);
    req_t r;
    r.lev = 5'($urandom_range(1, 18));
    r.x = 19'($urandom) & ~((19'd1 << (19 - r.lev)) - 1);
    r.y = 19'($urandom) & ~((19'd1 << (19 - r.lev)) - 1);
    r.z = 19'($urandom) & ~((19'd1 << (19 - r.lev)) - 1);
    r.e = e;
    return r;
  endfunction

  task automatic test_directed_edges();
    req_t r;
    // corners of the root, every edge, at level 18 and at level 1
    for (int e = 0; e < 12; e++) begin
      r = '{x: 19'h7ffff, y: 19'h7ffff, z: 19'h7ffff, lev: 5'd18, e: 4'(e)};
      send_word(r);
      r = '{x: 19'd0, y: 19'd0, z: 19'd0, lev: 5'd1, e: 4'(e)};
      send_word(r);
    end
  endtask

  task automatic test_odd_inputs();
    req_t r;
    // edge indices above eleven, level zero and above the top, unaligned
    for (int e = 12; e < 16; e++) send_word(rand_octant(4'(e)));
    r = '{x: 19'h40000, y: 19'h2aaaa, z: 19'h55555, lev: 5'd0, e: 4'd3};
    send_word(r);
    r = '{x: 19'h12345, y: 19'h7ffff, z: 19'h00001, lev: 5'd31, e: 4'd6};
    send_word(r);
    r = '{x: 19'h1ffff, y: 19'h3ffff, z: 19'h5ffff, lev: 5'd19, e: 4'd9};
    send_word(r);
  endtask

  task automatic test_random(input int n);
    req_t r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = '{x: 19'($urandom), y: 19'($urandom), z: 19'($urandom),
              lev: 5'($urandom), e: 4'($urandom)};
      end else begin
        r = rand_octant(4'($urandom_range(0, 11)));
      end
      send_word(r);
    end
  endtask

  // Stall the output side in random bursts.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      shift_t got, exp_s;
      got = '{out_if.mid_x, out_if.mid_y, out_if.mid_z, out_if.up_x, out_if.up_y,
              out_if.up_z, out_if.down_x, out_if.down_y, out_if.down_z,
              out_if.out_level};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, got);
        fail_cnt++;
      end else begin
        exp_s = expected_q.pop_front();
        if (got.mx  !== exp_s.mx  || got.my !== exp_s.my || got.mz !== exp_s.mz ||
            got.ux  !== exp_s.ux  || got.uy !== exp_s.uy || got.uz !== exp_s.uz ||
            got.dx  !== exp_s.dx  || got.dy !== exp_s.dy || got.dz !== exp_s.dz ||
            got.lev !== exp_s.lev) begin
          $display("%0t: mismatch expected mid %h %h %h up %h %h %h dn %h %h %h lev %0d",
                   $realtime, exp_s.mx, exp_s.my, exp_s.mz, exp_s.ux, exp_s.uy,
                   exp_s.uz, exp_s.dx, exp_s.dy, exp_s.dz, exp_s.lev);
          $display("%0t:          actual   mid %h %h %h up %h %h %h dn %h %h %h lev %0d",
                   $realtime, got.mx, got.my, got.mz, got.ux, got.uy, got.uz,
                   got.dx, got.dy, got.dz, got.lev);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cnt <= 0;
    end else if (rst_ni && (in_if.valid || expected_q.size() != 0)) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    fail_cnt = 0;
    idle_cnt = 0;
    quiet    = 1'b0;
    rst_ni   = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.in_x       <= '0;
    in_if.in_y       <= '0;
    in_if.in_z       <= '0;
    in_if.in_level   <= '0;
    in_if.edge_index <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_odd_inputs();
    test_random(850);
    quiet = 1'b1;
    test_random(170);
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/oes_pkg.sv
design/oes_in_if.sv
design/oes_out_if.sv
design/oes_prep.sv
design/oes_step.sv
design/oes_final.sv
design/octant_edge_shift.sv
verif/tb_octant_edge_shift.sv
